@@ src/led_pixel_spi_code_encoder_top_macros.svh @@
// Assertion macros used by the encoder back end
`ifndef LED_PIXEL_SPI_CODE_ENCODER_TOP_MACROS_SVH
`define LED_PIXEL_SPI_CODE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LPSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LPSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lpsc_pkg.sv @@
// Shared types, constants and the color scaling function of the LED code encoder
package lpsc_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int RESET_BYTES    = 24;
    localparam int CNT_W          = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [8:0] BRIGHTNESS_RST = 9'd13;
    localparam logic [7:0] ONE_CODE_RST   = 8'h3C;
    localparam logic [7:0] ZERO_CODE_RST  = 8'h30;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_ONE_CODE   = 2'd1,
        REG_ZERO_CODE  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DATA,
        BK_GAP
    } back_state_t;

    // One queued pixel: scaled GRB word and the end-of-frame flag
    typedef struct packed {
        logic [BITS_PER_PIXEL-1:0] word;
        logic                      final_pixel;
    } pix_entry_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic       empty;
        pix_entry_t head;
    } queue_stat_t;

    // (c * b) >> 8, saturated at 255
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] b);
        logic [16:0] prod;
        prod = {9'd0, c} * {8'd0, b};
        if (prod[16]) begin
            return 8'hFF;
        end
        return prod[15:8];
    endfunction

endpackage

@@ src/lpsc_front.sv @@
// Front end: accepts pixel beats, scales the colors and packs the GRB word
module lpsc_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_red,
    input  logic [7:0]           s_green,
    input  logic [7:0]           s_blue,
    input  logic                 s_final_pixel,
    input  logic [8:0]           brightness,
    input  logic                 q_full,
    output logic                 q_push,
    output lpsc_pkg::pix_entry_t q_push_data
);
    import lpsc_pkg::*;

    // Take a beat whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Scale each channel and order them green, red, blue
    always_comb begin
        q_push_data.word = {scale_chan(s_green, brightness),
                            scale_chan(s_red, brightness),
                            scale_chan(s_blue, brightness)};
        q_push_data.final_pixel = s_final_pixel;
    end

endmodule

@@ src/lpsc_queue.sv @@
// Two-entry queue between the front and back ends
module lpsc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lpsc_pkg::pix_entry_t  push_data,
    input  logic                  pop,
    output logic                  full,
    output lpsc_pkg::queue_stat_t stat
);
    import lpsc_pkg::*;

    pix_entry_t mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == 2'd0);
    assign stat.head  = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !stat.empty;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/lpsc_back.sv @@
// Back end: serializes each pixel into code bytes and appends the latch gap after an end-of-frame pixel
`include "led_pixel_spi_code_encoder_top_macros.svh"

module lpsc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpsc_pkg::queue_stat_t q_stat,
    output logic                  q_pop,
    input  logic [7:0]            one_code,
    input  logic [7:0]            zero_code,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_code_byte,
    output logic                  m_in_latch_gap,
    output logic                  m_run_end
);
    import lpsc_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0] LAST_GAP = CNT_W'(RESET_BYTES - 1);

    back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [BITS_PER_PIXEL-1:0] word_reg, word_next;
    logic                      final_reg, final_next;

    logic       m_valid_reg;
    logic [7:0] m_code_byte_reg;
    logic       m_in_latch_gap_reg;
    logic       m_run_end_reg;

    logic       out_free;
    logic       emit;
    logic [7:0] byte_sel;
    logic       gap_sel;
    logic       last_sel;

    // Output register can take a new byte
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = BK_DATA;
                end
            end
            BK_DATA: begin
                if (out_free && cnt_reg == LAST_BIT) begin
                    if (final_reg) begin
                        state_next = BK_GAP;
                    end else begin
                        state_next = q_stat.empty ? BK_IDLE : BK_DATA;
                    end
                end
            end
            BK_GAP: begin
                if (out_free && cnt_reg == LAST_GAP) begin
                    state_next = q_stat.empty ? BK_IDLE : BK_DATA;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Byte selection, counters and queue pop
    always_comb begin
        emit       = 1'b0;
        q_pop      = 1'b0;
        byte_sel   = 8'd0;
        gap_sel    = 1'b0;
        last_sel   = 1'b0;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        final_next = final_reg;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop = !q_stat.empty;
            end
            BK_DATA: begin
                if (out_free) begin
                    emit      = 1'b1;
                    byte_sel  = word_reg[BITS_PER_PIXEL-1] ? one_code : zero_code;
                    word_next = {word_reg[BITS_PER_PIXEL-2:0], 1'b0};
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_BIT) begin
                        cnt_next = '0;
                        if (!final_reg) begin
                            last_sel = 1'b1;
                            q_pop    = !q_stat.empty;
                        end
                    end
                end
            end
            BK_GAP: begin
                if (out_free) begin
                    emit     = 1'b1;
                    gap_sel  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_GAP) begin
                        cnt_next = '0;
                        last_sel = 1'b1;
                        q_pop    = !q_stat.empty;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
        // Load the next pixel from the queue head
        if (q_pop) begin
            word_next  = q_stat.head.word;
            final_next = q_stat.head.final_pixel;
            cnt_next   = '0;
        end
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        final_reg <= final_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_code_byte_reg    <= byte_sel;
            m_in_latch_gap_reg <= gap_sel;
            m_run_end_reg      <= last_sel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_code_byte    = m_code_byte_reg;
    assign m_in_latch_gap = m_in_latch_gap_reg;
    assign m_run_end      = m_run_end_reg;

    // Checks
    `LPSC_ASSERT_IMP(a_gap_byte_zero, m_valid_reg && m_in_latch_gap_reg, m_code_byte_reg == 8'd0, "latch gap beat with nonzero byte")
    `LPSC_ASSERT_IMP(a_pop_at_boundary, q_pop, state_reg == BK_IDLE || last_sel, "queue popped in the middle of a run")
    `LPSC_ASSERT_IMP(a_gap_needs_final, state_reg == BK_GAP, final_reg, "latch gap without end-of-frame pixel")
    `LPSC_ASSERT_IMP(a_cnt_range, state_reg == BK_DATA, cnt_reg <= LAST_BIT, "bit counter out of range")
    `LPSC_ASSERT_NXT(a_emit_valid, emit, m_valid_reg, "emitted byte not presented")

endmodule

@@ src/led_pixel_spi_code_encoder_top.sv @@
// Top level of the LED pixel to SPI code byte encoder
// Each accepted pixel beat yields 24 code bytes (G, R, B, MSB first), plus 24 zero
// latch-gap bytes when final_pixel is set; run_end marks the last byte of each pixel,
// or of its latch gap when there is one. The back end issues one byte per cycle into
// its output register while m_ready allows; pixels follow each other without bubbles
// while the queue holds one; a two-entry queue lets the input side take pixels as bytes drain.
// Colors are scaled as (c * brightness) >> 8, saturating at 255. Registers on the APB
// port: 0x0 brightness (9 bits, reset 13), 0x4 one_code (reset 0x3C), 0x8 zero_code
// (reset 0x30); write them only while the block is idle.
module led_pixel_spi_code_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        s_final_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_code_byte,
    output logic        m_in_latch_gap,
    output logic        m_run_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpsc_pkg::*;

    logic [8:0]  brightness_reg;
    logic [7:0]  one_code_reg;
    logic [7:0]  zero_code_reg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    logic        q_full;
    logic        q_push;
    pix_entry_t  q_push_data;
    logic        q_pop;
    queue_stat_t q_stat;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RST;
            one_code_reg   <= ONE_CODE_RST;
            zero_code_reg  <= ZERO_CODE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BRIGHTNESS: brightness_reg <= pwdata[8:0];
                REG_ONE_CODE:   one_code_reg   <= pwdata[7:0];
                REG_ZERO_CODE:  zero_code_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            REG_BRIGHTNESS: prdata = {23'd0, brightness_reg};
            REG_ONE_CODE:   prdata = {24'd0, one_code_reg};
            REG_ZERO_CODE:  prdata = {24'd0, zero_code_reg};
            default:        prdata = 32'd0;
        endcase
    end

    lpsc_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_final_pixel (s_final_pixel),
        .brightness    (brightness_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    lpsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .stat      (q_stat)
    );

    lpsc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .one_code       (one_code_reg),
        .zero_code      (zero_code_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_byte    (m_code_byte),
        .m_in_latch_gap (m_in_latch_gap),
        .m_run_end      (m_run_end)
    );

endmodule
